// ===== src/i2cmts_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cmts_pkg
// Shared types, codes and constants of the I2C master transfer sequencer.
// ----------------------------------------------------------------------------
package i2cmts_pkg;

  // transmit store depth and its address width
  localparam int unsigned MaxBytes = 256;
  localparam int unsigned AddrW    = $clog2(MaxBytes);

  // controller states, numbered as reported in state_code
  typedef enum logic [2:0] {
    StStopped = 3'd0,
    StIdle    = 3'd1,
    StBusy    = 3'd2,
    StDone    = 3'd3,
    StDoneStp = 3'd4,
    StError   = 3'd5
  } state_e;

  // item kinds
  typedef enum logic [1:0] {
    ReqEvent = 2'd0,
    ReqLoad  = 2'd1,
    ReqStart = 2'd2,
    ReqRead  = 2'd3
  } req_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CfgSlaveAddr = 2'd0,
    CfgReadMode  = 2'd1,
    CfgAutoStop  = 2'd2,
    CfgLength    = 2'd3
  } cfg_idx_e;

  // bus status codes
  localparam logic [7:0] StaStart    = 8'h08;
  localparam logic [7:0] StaRepStart = 8'h10;
  localparam logic [7:0] StaAddrAck  = 8'h18;
  localparam logic [7:0] StaDataAck  = 8'h28;
  localparam logic [7:0] StaDataNack = 8'h30;
  localparam logic [7:0] StaRxAddr   = 8'h40;
  localparam logic [7:0] StaRxAck    = 8'h50;
  localparam logic [7:0] StaRxNack   = 8'h58;
  localparam logic [7:0] StaNoInfo   = 8'hF8;

  // control set bits
  localparam logic [2:0] SetAck   = 3'b001;
  localparam logic [2:0] SetStop  = 3'b010;
  localparam logic [2:0] SetStart = 3'b100;

  // control clear bits
  localparam logic [2:0] ClrAck   = 3'b001;
  localparam logic [2:0] ClrFlag  = 3'b010;
  localparam logic [2:0] ClrStart = 3'b100;

  // configuration registers
  typedef struct packed {
    logic [6:0] slave_address;
    logic       read_mode;
    logic       stop_on_done;
    logic [8:0] transfer_length;
  } cfg_t;

  // controller state registers
  typedef struct packed {
    state_e     state;
    logic [8:0] pos;
    logic [7:0] last_status;
    logic       events_en;
  } ctl_t;

  // one input item
  typedef struct packed {
    req_e       req_type;
    logic [7:0] status_code;
    logic [7:0] bus_byte;
    logic [7:0] load_index;
  } item_t;

  // one result item
  typedef struct packed {
    logic [2:0] ctrl_set;
    logic [2:0] ctrl_clear;
    logic       data_write_valid;
    logic [7:0] data_out;
    logic       rx_valid;
    logic [7:0] rx_index;
    logic [2:0] state_code;
    logic [7:0] error_code;
    logic       accepted;
    logic       irq_enable;
  } res_t;

  // transmit store write request
  typedef struct packed {
    logic             we;
    logic [AddrW-1:0] addr;
    logic [7:0]       data;
  } wr_t;

endpackage

// ===== src/i2c_master_transfer_sequencer_top.sv =====
// ----------------------------------------------------------------------------
// i2c_master_transfer_sequencer_top
// Status-driven I2C master transfer sequencer with streaming ports.
// ----------------------------------------------------------------------------
// Each transaction on the input stream gives exactly one result transaction.
// The block takes one item per clock cycle while the result stream is not
// stalled: an item is captured in an input register, decided in one pass of
// logic against the controller state, and its result is held in an output
// register; a stalled result still lets one more item in. The rate is set
// by the state update loop. The 256-entry transmit store is a RAM read ahead
// at the next byte position, with a forward of a load to that same position;
// it needs no clearing pass after reset. The user must write configuration
// registers only while the block is idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module i2c_master_transfer_sequencer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_addr_i,
  input  logic [8:0]  cfg_wdata_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // status_code [7:0], bus_byte [15:8], load_index [23:16]
  input  logic [23:0] s_axis_tdata,
  // req_type [1:0]
  input  logic [1:0]  s_axis_tuser,
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // ctrl_set [2:0], ctrl_clear [5:3], data_write_valid [6], data_out [14:7],
  // rx_valid [15], rx_index [23:16], state_code [26:24], error_code [34:27],
  // accepted [35], irq_enable [36], zero [39:37]
  output logic [39:0] m_axis_tdata
);

  i2cmts_pkg::cfg_t  cfg_q;
  i2cmts_pkg::ctl_t  ctl_q, ctl_d, ctl_nxt;
  i2cmts_pkg::item_t item_q;
  i2cmts_pkg::res_t  res, res_q;
  i2cmts_pkg::wr_t   wr;
  logic              in_valid_q;
  logic              out_valid_q;
  logic              in_fire;
  logic              advance;
  logic              ram_we;
  logic [i2cmts_pkg::AddrW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic              byp_valid_q;
  logic [7:0]        byp_data_q;
  logic              pos_in_range;
  logic [7:0]        tx_byte;

  // handshake
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      unique case (i2cmts_pkg::cfg_idx_e'(cfg_addr_i))
        i2cmts_pkg::CfgSlaveAddr: cfg_q.slave_address   <= cfg_wdata_i[6:0];
        i2cmts_pkg::CfgReadMode:  cfg_q.read_mode       <= cfg_wdata_i[0];
        i2cmts_pkg::CfgAutoStop:  cfg_q.stop_on_done    <= cfg_wdata_i[0];
        i2cmts_pkg::CfgLength:    cfg_q.transfer_length <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_fire) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q.req_type    <= i2cmts_pkg::req_e'(s_axis_tuser);
      item_q.status_code <= s_axis_tdata[7:0];
      item_q.bus_byte    <= s_axis_tdata[15:8];
      item_q.load_index  <= s_axis_tdata[23:16];
    end
  end

  // transmit byte at the current position, zero past the store
  assign pos_in_range = 32'(ctl_q.pos) < i2cmts_pkg::MaxBytes;
  assign tx_byte      = !pos_in_range ? 8'd0 : (byp_valid_q ? byp_data_q : ram_rdata);

  // item decision
  i2cmts_seq u_seq (
    .item_i    (item_q),
    .ctl_i     (ctl_q),
    .cfg_i     (cfg_q),
    .tx_byte_i (tx_byte),
    .ctl_o     (ctl_nxt),
    .res_o     (res),
    .wr_o      (wr)
  );

  // controller state register
  assign ctl_d = advance ? ctl_nxt : ctl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q.state       <= i2cmts_pkg::StStopped;
      ctl_q.pos         <= '0;
      ctl_q.last_status <= '0;
      ctl_q.events_en   <= 1'b0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // transmit store, read ahead at the next position
  assign ram_we    = advance && wr.we;
  assign ram_raddr = i2cmts_pkg::AddrW'(ctl_d.pos);

  i2cmts_ram #(
    .Width (8),
    .Depth (i2cmts_pkg::MaxBytes)
  ) u_tx_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr.addr),
    .wdata_i (wr.data),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // forward a load that lands on the address being read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_valid_q <= 1'b0;
    end else begin
      byp_valid_q <= ram_we && (wr.addr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    byp_data_q <= wr.data;
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res;
    end
  end

  // result packing
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000,
                          res_q.irq_enable,
                          res_q.accepted,
                          res_q.error_code,
                          res_q.state_code,
                          res_q.rx_index,
                          res_q.rx_valid,
                          res_q.data_out,
                          res_q.data_write_valid,
                          res_q.ctrl_clear,
                          res_q.ctrl_set};

endmodule

// ===== src/i2cmts_ram.sv =====
// ----------------------------------------------------------------------------
// i2cmts_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module i2cmts_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write port and registered read, old data on a same-address collision
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/i2cmts_seq.sv =====
// ----------------------------------------------------------------------------
// i2cmts_seq
// Next-state and result logic for one item of the transfer sequencer.
// ----------------------------------------------------------------------------
module i2cmts_seq (
  input  i2cmts_pkg::item_t item_i,
  input  i2cmts_pkg::ctl_t  ctl_i,
  input  i2cmts_pkg::cfg_t  cfg_i,
  input  logic [7:0]        tx_byte_i,
  output i2cmts_pkg::ctl_t  ctl_o,
  output i2cmts_pkg::res_t  res_o,
  output i2cmts_pkg::wr_t   wr_o
);

  logic                signed [10:0] pos_s;
  logic                signed [10:0] len_s;
  logic                       fail;
  logic                       finish;
  i2cmts_pkg::state_e         shown;

  assign pos_s = $signed({2'b00, ctl_i.pos});
  assign len_s = $signed({2'b00, cfg_i.transfer_length});

  // decode the item against the controller state
  always_comb begin
    ctl_o   = ctl_i;
    res_o   = '0;
    wr_o    = '0;
    fail    = 1'b0;
    finish  = 1'b0;
    shown   = ctl_i.state;

    unique case (item_i.req_type)
      i2cmts_pkg::ReqEvent: begin
        if (ctl_i.events_en) begin
          res_o.accepted    = 1'b1;
          ctl_o.last_status = item_i.status_code;
          unique case (item_i.status_code)
            // start or repeated start: send address with direction
            i2cmts_pkg::StaStart, i2cmts_pkg::StaRepStart: begin
              ctl_o.state            = i2cmts_pkg::StBusy;
              res_o.data_write_valid = 1'b1;
              res_o.data_out         = {cfg_i.slave_address, cfg_i.read_mode};
              res_o.ctrl_clear       = i2cmts_pkg::ClrFlag | i2cmts_pkg::ClrStart;
            end
            // transmit acknowledged: next byte or completion
            i2cmts_pkg::StaAddrAck, i2cmts_pkg::StaDataAck: begin
              if (cfg_i.read_mode) begin
                fail = 1'b1;
              end else if (pos_s < len_s) begin
                res_o.data_write_valid = 1'b1;
                res_o.data_out         = tx_byte_i;
                ctl_o.pos              = ctl_i.pos + 9'd1;
                res_o.ctrl_clear       = i2cmts_pkg::ClrFlag;
              end else begin
                finish = 1'b1;
              end
            end
            // data not acknowledged: fine only after the last byte
            i2cmts_pkg::StaDataNack: begin
              if (cfg_i.read_mode || (ctl_i.pos != cfg_i.transfer_length)) begin
                fail = 1'b1;
              end else begin
                finish = 1'b1;
              end
            end
            // address acknowledged for receive
            i2cmts_pkg::StaRxAddr: begin
              if (!cfg_i.read_mode) begin
                fail = 1'b1;
              end else begin
                if (pos_s < (len_s - 11'sd1)) begin
                  res_o.ctrl_set = i2cmts_pkg::SetAck;
                end else begin
                  res_o.ctrl_clear = i2cmts_pkg::ClrAck;
                end
                res_o.ctrl_clear = res_o.ctrl_clear | i2cmts_pkg::ClrFlag;
              end
            end
            // byte received and acknowledged
            i2cmts_pkg::StaRxAck: begin
              if (!cfg_i.read_mode) begin
                fail = 1'b1;
              end else begin
                res_o.rx_valid = 1'b1;
                res_o.rx_index = ctl_i.pos[7:0];
                if (pos_s < (len_s - 11'sd2)) begin
                  res_o.ctrl_set = i2cmts_pkg::SetAck;
                end else begin
                  res_o.ctrl_clear = i2cmts_pkg::ClrAck;
                end
                ctl_o.pos        = ctl_i.pos + 9'd1;
                res_o.ctrl_clear = res_o.ctrl_clear | i2cmts_pkg::ClrFlag;
              end
            end
            // last byte received without acknowledge
            i2cmts_pkg::StaRxNack: begin
              if (!cfg_i.read_mode || (pos_s != (len_s - 11'sd1))) begin
                fail = 1'b1;
              end else begin
                res_o.rx_valid = 1'b1;
                res_o.rx_index = ctl_i.pos[7:0];
                finish         = 1'b1;
              end
            end
            // no relevant status: nothing to do
            i2cmts_pkg::StaNoInfo: begin
            end
            default: begin
              fail = 1'b1;
            end
          endcase

          // transfer complete
          if (finish) begin
            if (cfg_i.stop_on_done) begin
              res_o.ctrl_set   = res_o.ctrl_set | i2cmts_pkg::SetStop;
              res_o.ctrl_clear = res_o.ctrl_clear | i2cmts_pkg::ClrFlag;
              ctl_o.state      = i2cmts_pkg::StDoneStp;
            end else begin
              ctl_o.state = i2cmts_pkg::StDone;
            end
            ctl_o.events_en = 1'b0;
          end

          // unexpected code: error and stop
          if (fail) begin
            ctl_o.state      = i2cmts_pkg::StError;
            res_o.ctrl_set   = i2cmts_pkg::SetStop;
            res_o.ctrl_clear = i2cmts_pkg::ClrFlag;
            ctl_o.events_en  = 1'b0;
          end
        end
        shown = ctl_o.state;
      end

      // load a transmit byte when not busy
      i2cmts_pkg::ReqLoad: begin
        if ((ctl_i.state != i2cmts_pkg::StBusy) &&
            (32'(item_i.load_index) < i2cmts_pkg::MaxBytes)) begin
          wr_o.we        = 1'b1;
          wr_o.addr      = i2cmts_pkg::AddrW'(item_i.load_index);
          wr_o.data      = item_i.bus_byte;
          res_o.accepted = 1'b1;
        end
      end

      // start a transfer unless busy
      i2cmts_pkg::ReqStart: begin
        if (ctl_i.state != i2cmts_pkg::StBusy) begin
          ctl_o.pos      = '0;
          res_o.ctrl_set = i2cmts_pkg::SetStart;
          if (ctl_i.state == i2cmts_pkg::StIdle) begin
            res_o.ctrl_clear = i2cmts_pkg::ClrFlag;
          end
          ctl_o.events_en = 1'b1;
          res_o.accepted  = 1'b1;
        end
      end

      // status read reports the state before it and retires done states
      i2cmts_pkg::ReqRead: begin
        if (ctl_i.state == i2cmts_pkg::StDone) begin
          ctl_o.state = i2cmts_pkg::StIdle;
        end else if (ctl_i.state == i2cmts_pkg::StDoneStp) begin
          ctl_o.state = i2cmts_pkg::StStopped;
        end
        res_o.accepted = 1'b1;
      end

      default: begin
      end
    endcase

    res_o.state_code = shown;
    res_o.error_code = (shown == i2cmts_pkg::StError) ? ctl_o.last_status : 8'd0;
    res_o.irq_enable = ctl_o.events_en;
  end

endmodule
